// ===== design/angle_kalman_filter_assert.svh =====
// Assertion macros shared by the angle Kalman filter RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef ANGLE_KALMAN_FILTER_ASSERT_SVH
`define ANGLE_KALMAN_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define AKF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define AKF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AKF_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define AKF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/akf_pkg.sv =====
// Types and constants for the angle Kalman filter.
// No dependencies.
package akf_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned ProdW = 64;
    localparam int unsigned CntW  = 7;

    typedef enum logic [1:0] {
        REG_TIME_STEP     = 2'd0,
        REG_ANGLE_NOISE   = 2'd1,
        REG_BIAS_NOISE    = 2'd2,
        REG_MEASURE_NOISE = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] dst;
        logic [3:0] src_a;
        logic [3:0] src_b;
    } uop_t;

    // Register file slots.
    localparam logic [3:0] R_DT = 4'd0, R_QA = 4'd1, R_QB = 4'd2, R_R = 4'd3,
        R_RATE = 4'd4, R_ACC = 4'd5, R_ANG = 4'd6, R_BIAS = 4'd7,
        R_P00 = 4'd8, R_P01 = 4'd9, R_P10 = 4'd10, R_P11 = 4'd11,
        R_T = 4'd12, R_U = 4'd13, R_K0 = 4'd14, R_K1 = 4'd15;

    localparam int unsigned UopW = 6;

    // R_ANG holds the predicted angle from step 2 on; R_T and R_U are scratch,
    // and R_U holds s, then the innovation.
    function automatic uop_t uop_at(logic [UopW-1:0] pc);
        uop_t u;
        u = '{OP_ADD, R_T, R_T, R_T};
        case (pc)
            6'd0:  u = '{OP_SUB, R_U, R_RATE, R_BIAS};
            6'd1:  u = '{OP_MUL, R_U, R_DT, R_U};
            6'd2:  u = '{OP_ADD, R_ANG, R_ANG, R_U};
            6'd3:  u = '{OP_MUL, R_T, R_DT, R_P11};
            6'd4:  u = '{OP_SUB, R_T, R_T, R_P01};
            6'd5:  u = '{OP_SUB, R_T, R_T, R_P10};
            6'd6:  u = '{OP_ADD, R_T, R_T, R_QA};
            6'd7:  u = '{OP_MUL, R_T, R_DT, R_T};
            6'd8:  u = '{OP_ADD, R_P00, R_P00, R_T};
            6'd9:  u = '{OP_MUL, R_T, R_DT, R_P11};
            6'd10: u = '{OP_SUB, R_P01, R_P01, R_T};
            6'd11: u = '{OP_SUB, R_P10, R_P10, R_T};
            6'd12: u = '{OP_MUL, R_T, R_QB, R_DT};
            6'd13: u = '{OP_ADD, R_P11, R_P11, R_T};
            6'd14: u = '{OP_ADD, R_U, R_P00, R_R};
            6'd15: u = '{OP_DIV, R_K0, R_P00, R_U};
            6'd16: u = '{OP_DIV, R_K1, R_P10, R_U};
            6'd17: u = '{OP_SUB, R_U, R_ACC, R_ANG};
            6'd18: u = '{OP_MUL, R_T, R_K0, R_U};
            6'd19: u = '{OP_ADD, R_ANG, R_ANG, R_T};
            6'd20: u = '{OP_MUL, R_T, R_K1, R_U};
            6'd21: u = '{OP_ADD, R_BIAS, R_BIAS, R_T};
            6'd22: u = '{OP_MUL, R_T, R_K0, R_P00};
            6'd23: u = '{OP_MUL, R_U, R_K1, R_P00};
            6'd24: u = '{OP_SUB, R_P10, R_P10, R_U};
            6'd25: u = '{OP_SUB, R_P00, R_P00, R_T};
            6'd26: u = '{OP_MUL, R_T, R_K0, R_P01};
            6'd27: u = '{OP_MUL, R_U, R_K1, R_P01};
            6'd28: u = '{OP_SUB, R_P11, R_P11, R_U};
            6'd29: u = '{OP_SUB, R_P01, R_P01, R_T};
            default: u = '{OP_ADD, R_T, R_T, R_T};
        endcase
        return u;
    endfunction

    localparam logic [UopW-1:0] LastPc = 6'd29;
endpackage

// ===== design/angle_kalman_filter.sv =====
// Angle Kalman filter top level: a micro-coded sequencer over one bit-serial
// multiply and divide unit plus a combinational saturating adder. Uses akf_pkg.
//
//  channel | dir | handshake               | payload
//  s_      | in  | s_tvalid / s_tready     | s_tdata: gyro_rate, accel_angle
//  m_      | out | m_tvalid / m_tready     | m_tdata: angle_estimate; m_tuser: saturated
//  cfg_    | in  | cfg_wr_en               | cfg_index, cfg_data
//
// One item runs 30 micro-steps: 17 adds, 11 multiplies (load, one step per
// multiplier bit, write) and 2 divisions (load, one step per quotient bit, write);
// a division by a non-positive sum writes zero and sets the saturated flag.
// Reset (aresetn low, synchronous) restores the constants, estimate, covariance and state.
// A new item is taken once the previous result has left the output register.
module angle_kalman_filter #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] gyro_rate, [15:8] accel_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] angle_estimate
    output logic        m_tuser,   // [0] saturated
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    localparam int unsigned W = akf_pkg::WordW;
    localparam int unsigned PW = akf_pkg::ProdW;
    localparam int unsigned DivBits = W + FRAC_BITS;
    localparam int unsigned DivCntW = $clog2(DivBits + 1);
    localparam logic signed [PW-1:0] MaxW = PW'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [PW-1:0] MinW = -PW'(64'sh0000_0000_8000_0000);

    typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_MUL, ST_DIV, ST_OUT} state_t;

    state_t state_reg;
    logic [akf_pkg::UopW-1:0] pc_reg;
    logic signed [W-1:0] rf_reg [16];
    logic clip_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic [W-1:0] mcand_reg;
    logic [W-1:0] mplier_reg;
    logic signed [PW-1:0] acc_reg;
    logic a_neg_reg, b_neg_reg;
    logic [DivBits-1:0] dnum_reg;
    logic [W:0] rem_reg;
    logic [W-1:0] dden_reg;
    logic [DivBits-1:0] quo_reg;
    logic res_neg_reg;
    logic m_tvalid_reg;
    logic [W-1:0] m_tdata_reg;
    logic m_tuser_reg;

    akf_pkg::uop_t uop;
    logic signed [W-1:0] opa, opb;
    logic signed [W+1:0] addsub;
    logic signed [W-1:0] sat_add;
    logic add_clip;
    logic signed [PW-1:0] prod_full, prod_sh;
    logic signed [W-1:0] mul_res;
    logic mul_clip;
    logic [W:0] rem_try;
    logic [W:0] rem_sh;
    logic signed [PW-1:0] quo_s;
    logic signed [W-1:0] div_res;
    logic div_clip;
    logic [W-1:0] mag_a;

    assign uop = akf_pkg::uop_at(pc_reg);
    assign opa = rf_reg[uop.src_a];
    assign opb = rf_reg[uop.src_b];
    assign addsub = (uop.op == akf_pkg::OP_SUB) ? (W+2)'(opa) - (W+2)'(opb)
                                                 : (W+2)'(opa) + (W+2)'(opb);
    always_comb begin
        add_clip = 1'b0;
        sat_add = addsub[W-1:0];
        if (addsub > (W+2)'(MaxW)) begin
            add_clip = 1'b1;
            sat_add = W'(MaxW);
        end else if (addsub < (W+2)'(MinW)) begin
            add_clip = 1'b1;
            sat_add = W'(MinW);
        end
    end

    // Signed product from magnitude accumulation; arithmetic shift floors.
    assign prod_full = (a_neg_reg ^ b_neg_reg) ? -acc_reg : acc_reg;
    assign prod_sh = prod_full >>> FRAC_BITS;
    always_comb begin
        mul_clip = 1'b0;
        mul_res = prod_sh[W-1:0];
        if (prod_sh > MaxW) begin
            mul_clip = 1'b1;
            mul_res = W'(MaxW);
        end else if (prod_sh < MinW) begin
            mul_clip = 1'b1;
            mul_res = W'(MinW);
        end
    end

    assign rem_sh = {rem_reg[W-1:0], dnum_reg[DivBits-1]};
    assign rem_try = rem_sh - {1'b0, dden_reg};
    assign quo_s = res_neg_reg ? -PW'(quo_reg) : PW'(quo_reg);
    always_comb begin
        div_clip = 1'b0;
        div_res = quo_s[W-1:0];
        if (quo_s > MaxW) begin
            div_clip = 1'b1;
            div_res = W'(MaxW);
        end else if (quo_s < MinW) begin
            div_clip = 1'b1;
            div_res = W'(MinW);
        end
    end
    assign mag_a = opa[W-1] ? W'(-opa) : W'(opa);

    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            clip_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg <= '0;
            rf_reg[akf_pkg::R_DT] <= W'(655);
            rf_reg[akf_pkg::R_QA] <= W'(66);
            rf_reg[akf_pkg::R_QB] <= W'(197);
            rf_reg[akf_pkg::R_R] <= W'(1966);
            rf_reg[akf_pkg::R_ANG] <= '0;
            rf_reg[akf_pkg::R_BIAS] <= '0;
            rf_reg[akf_pkg::R_P00] <= W'(1) << FRAC_BITS;
            rf_reg[akf_pkg::R_P01] <= '0;
            rf_reg[akf_pkg::R_P10] <= '0;
            rf_reg[akf_pkg::R_P11] <= W'(1) << FRAC_BITS;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (akf_pkg::reg_idx_t'(cfg_index))
                    akf_pkg::REG_TIME_STEP:
                        rf_reg[akf_pkg::R_DT] <= W'(cfg_data[15:0]);
                    akf_pkg::REG_ANGLE_NOISE: rf_reg[akf_pkg::R_QA] <= W'(cfg_data);
                    akf_pkg::REG_BIAS_NOISE:  rf_reg[akf_pkg::R_QB] <= W'(cfg_data);
                    akf_pkg::REG_MEASURE_NOISE: rf_reg[akf_pkg::R_R] <= W'(cfg_data);
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        // Whole-unit inputs shifted into fixed point, clipped if needed.
                        rf_reg[akf_pkg::R_RATE] <= W'(
                            (PW'($signed(s_tdata[7:0])) <<< FRAC_BITS) > MaxW ? MaxW :
                            (PW'($signed(s_tdata[7:0])) <<< FRAC_BITS) < MinW ? MinW :
                            (PW'($signed(s_tdata[7:0])) <<< FRAC_BITS));
                        rf_reg[akf_pkg::R_ACC] <= W'(
                            (PW'($signed(s_tdata[15:8])) <<< FRAC_BITS) > MaxW ? MaxW :
                            (PW'($signed(s_tdata[15:8])) <<< FRAC_BITS) < MinW ? MinW :
                            (PW'($signed(s_tdata[15:8])) <<< FRAC_BITS));
                        clip_reg <= 1'b0;
                        pc_reg <= '0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    unique case (uop.op) inside
                        akf_pkg::OP_ADD, akf_pkg::OP_SUB: begin
                            rf_reg[uop.dst] <= sat_add;
                            clip_reg <= clip_reg | add_clip;
                            if (pc_reg == akf_pkg::LastPc) begin
                                state_reg <= ST_OUT;
                            end else begin
                                pc_reg <= pc_reg + 1'b1;
                            end
                        end
                        akf_pkg::OP_MUL: begin
                            mcand_reg <= mag_a;
                            mplier_reg <= opb[W-1] ? W'(-opb) : W'(opb);
                            a_neg_reg <= opa[W-1];
                            b_neg_reg <= opb[W-1];
                            acc_reg <= '0;
                            cnt_reg <= DivCntW'(W);
                            state_reg <= ST_MUL;
                        end
                        default: begin
                            if (opb > 0) begin
                                dnum_reg <= DivBits'(mag_a) << FRAC_BITS;
                                dden_reg <= opb;
                                rem_reg <= '0;
                                quo_reg <= '0;
                                res_neg_reg <= opa[W-1];
                                cnt_reg <= DivCntW'(DivBits);
                                state_reg <= ST_DIV;
                            end else begin
                                rf_reg[uop.dst] <= '0;
                                clip_reg <= 1'b1;
                                pc_reg <= pc_reg + 1'b1;
                            end
                        end
                    endcase
                end
                ST_MUL: begin
                    if (cnt_reg == '0) begin
                        rf_reg[uop.dst] <= mul_res;
                        clip_reg <= clip_reg | mul_clip;
                        pc_reg <= pc_reg + 1'b1;
                        state_reg <= ST_FETCH;
                    end else begin
                        // Multiplier bit from the top, accumulator doubles each step.
                        acc_reg <= (acc_reg <<< 1) +
                            (mplier_reg[W-1] ? PW'(mcand_reg) : PW'(0));
                        mplier_reg <= mplier_reg << 1;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == '0) begin
                        rf_reg[uop.dst] <= div_res;
                        clip_reg <= clip_reg | div_clip;
                        pc_reg <= pc_reg + 1'b1;
                        state_reg <= ST_FETCH;
                    end else begin
                        if (!rem_try[W]) begin
                            rem_reg <= rem_try;
                            quo_reg <= {quo_reg[DivBits-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[DivBits-2:0], 1'b0};
                        end
                        dnum_reg <= dnum_reg << 1;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_OUT: begin
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg <= rf_reg[akf_pkg::R_ANG];
                    m_tuser_reg <= clip_reg;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`include "angle_kalman_filter_assert.svh"

    `AKF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `AKF_ASSERT_IMP(a_busy_no_take, aclk, aresetn, state_reg != ST_IDLE, !s_tready, "item taken while busy")
    `AKF_ASSERT_NEXT(a_take_starts, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_FETCH && pc_reg == '0, "sequence not started")
    `AKF_ASSERT_NEXT(a_out_from_last, aclk, aresetn, state_reg == ST_OUT, m_tvalid && state_reg == ST_IDLE, "result not posted")
endmodule
